// ===== src/jase_pkg.sv =====
// Shared types and constants for the application segment value extractor.
package jase_pkg;

  localparam int unsigned VALUES_PER_WORD = 10;
  localparam int unsigned FIELD_W         = 3;
  localparam int unsigned WORD_W          = VALUES_PER_WORD * FIELD_W;

  localparam logic [7:0]  MARKER_PREFIX   = 8'hFF;
  localparam logic [63:0] TAG_WORD_RESET  = 64'h4752_4D3A_4356_443A;
  localparam logic [7:0]  MARKER_RESET    = 8'hED;
  localparam logic [15:0] MIN_TAG_LEN     = 16'd8;
  localparam logic [15:0] HEADER_LEN      = 16'd10;

  localparam logic REG_TAG_WORD    = 1'b0;
  localparam logic REG_MARKER_CODE = 1'b1;

  typedef enum logic [1:0] {
    PH_SCAN = 2'd0,
    PH_LEN  = 2'd1,
    PH_TAG  = 2'd2,
    PH_WORD = 2'd3
  } phase_t;

  typedef struct packed {
    logic              push;
    logic [WORD_W-1:0] word;
  } word_req_t;

endpackage

// ===== src/jase_parser.sv =====
// Byte parser: marker scan, length, tag check and packed word assembly.
module jase_parser import jase_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        start_of_file,
  input  logic        buf_free,
  output logic        in_ready,
  output word_req_t   word_req
);

  logic [63:0] tag_word;
  logic [7:0]  marker_code;

  phase_t      phase, phase_next;
  logic [7:0]  previous_byte, previous_byte_next;
  logic [3:0]  byte_counter, byte_counter_next;
  logic [15:0] segment_length, segment_length_next;
  logic [63:0] tag_shift, tag_shift_next;
  logic [23:0] word_shift, word_shift_next;
  logic [13:0] words_left, words_left_next;
  logic [15:0] len_rest;
  logic [13:0] word_count;
  logic [31:0] word_full;

  assign in_ready = !(phase == PH_WORD && byte_counter == 4'd3) || buf_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_word    <= TAG_WORD_RESET;
      marker_code <= MARKER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TAG_WORD:    tag_word    <= cfg_data;
        REG_MARKER_CODE: marker_code <= cfg_data[7:0];
        default:         tag_word    <= tag_word;
      endcase
    end
  end

  always_comb begin
    phase_next          = phase;
    previous_byte_next  = previous_byte;
    byte_counter_next   = byte_counter;
    segment_length_next = segment_length;
    tag_shift_next      = tag_shift;
    word_shift_next     = word_shift;
    words_left_next     = words_left;
    word_req.push       = 1'b0;
    word_full           = {word_shift, data_byte};
    word_req.word       = word_full[WORD_W-1:0];
    if (start_of_file) begin
      phase_next          = PH_SCAN;
      previous_byte_next  = '0;
      byte_counter_next   = '0;
      segment_length_next = '0;
      tag_shift_next      = '0;
      word_shift_next     = '0;
      words_left_next     = '0;
    end
    len_rest   = segment_length_next - HEADER_LEN;
    word_count = (segment_length_next >= HEADER_LEN) ? len_rest[15:2] : '0;
    unique case (phase_next)
      PH_LEN: begin
        if (byte_counter_next == 4'd0) begin
          segment_length_next = {data_byte, 8'd0};
          byte_counter_next   = 4'd1;
        end else begin
          segment_length_next = {segment_length_next[15:8], data_byte};
          byte_counter_next   = 4'd0;
          if (segment_length_next >= MIN_TAG_LEN) begin
            phase_next     = PH_TAG;
            tag_shift_next = '0;
          end else begin
            phase_next         = PH_SCAN;
            previous_byte_next = '0;
          end
        end
      end
      PH_TAG: begin
        tag_shift_next    = {tag_shift_next[55:0], data_byte};
        byte_counter_next = byte_counter_next + 4'd1;
        if (byte_counter_next >= 4'd8) begin
          byte_counter_next = 4'd0;
          if (tag_shift_next == tag_word && word_count != '0) begin
            phase_next      = PH_WORD;
            word_shift_next = '0;
            words_left_next = word_count;
          end else begin
            phase_next         = PH_SCAN;
            previous_byte_next = '0;
          end
        end
      end
      PH_WORD: begin
        if (byte_counter_next < 4'd3) begin
          word_shift_next   = {word_shift_next[15:0], data_byte};
          byte_counter_next = byte_counter_next + 4'd1;
        end else begin
          word_full         = {word_shift_next, data_byte};
          word_req.word     = word_full[WORD_W-1:0];
          word_req.push     = accept && (data_byte[FIELD_W-1:0] != '0);
          byte_counter_next = 4'd0;
          word_shift_next   = '0;
          words_left_next   = words_left_next - 14'd1;
          if (words_left_next == '0) begin
            phase_next         = PH_SCAN;
            previous_byte_next = '0;
          end
        end
      end
      default: begin
        if (previous_byte_next == MARKER_PREFIX && data_byte == marker_code) begin
          phase_next          = PH_LEN;
          byte_counter_next   = 4'd0;
          segment_length_next = '0;
        end
        previous_byte_next = data_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SCAN;
      previous_byte  <= '0;
      byte_counter   <= '0;
      segment_length <= '0;
      tag_shift      <= '0;
      word_shift     <= '0;
      words_left     <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      previous_byte  <= previous_byte_next;
      byte_counter   <= byte_counter_next;
      segment_length <= segment_length_next;
      tag_shift      <= tag_shift_next;
      word_shift     <= word_shift_next;
      words_left     <= words_left_next;
    end
  end

  a_word_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_WORD |-> words_left != '0)
    else $error("word phase with no words left");

  a_len_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LEN |-> byte_counter <= 4'd1)
    else $error("length byte counter out of range");

endmodule

// ===== src/jase_emitter.sv =====
// Word buffer and output register that drain packed fields one per cycle while the output is not stalled.
module jase_emitter import jase_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  word_req_t           word_req,
  output logic                buf_free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FIELD_W-1:0]  value,
  output logic                last_in_word
);

  logic              word_valid;
  logic [WORD_W-1:0] word;
  logic              load;
  logic              field_last;

  assign load       = word_valid && (!out_valid || out_ready);
  assign field_last = (word[2*FIELD_W-1:FIELD_W] == '0);
  assign buf_free   = !word_valid || (load && field_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (word_req.push) begin
      word_valid <= 1'b1;
    end else if (load && field_last) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (word_req.push) begin
      word <= word_req.word;
    end else if (load) begin
      word <= {{FIELD_W{1'b0}}, word[WORD_W-1:FIELD_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value        <= word[FIELD_W-1:0];
      last_in_word <= field_last;
    end
  end

  a_value_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> value != '0)
    else $error("zero value on output");

  a_word_nonzero: assert property (@(posedge clk) disable iff (rst)
    word_valid |-> word[FIELD_W-1:0] != '0)
    else $error("buffered word has no value left");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    word_req.push |-> buf_free)
    else $error("word pushed into a busy buffer");

endmodule

// ===== src/jpeg_app_segment_value_extractor_top.sv =====
// Top level of the application segment value extractor.
// A word is buffered once its fourth byte is accepted; values leave via the output register.
// Throughput: one byte per cycle while in_ready is high; with out_ready high, values drain one
// per cycle from a one-word buffer, so a word with n > 4 values delays the next word's last byte.
// Reset: rst (synchronous) restores both registers and returns the parser to scanning.
// start_of_file returns the parser to scanning for that byte without touching registers.
module jpeg_app_segment_value_extractor_top import jase_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   data_byte,
  input  logic         start_of_file,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [2:0]   value,
  output logic         last_in_word
);

  word_req_t word_req;
  logic      buf_free;

  jase_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (in_valid && in_ready),
    .data_byte     (data_byte),
    .start_of_file (start_of_file),
    .buf_free      (buf_free),
    .in_ready      (in_ready),
    .word_req      (word_req)
  );

  jase_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .word_req     (word_req),
    .buf_free     (buf_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value        (value),
    .last_in_word (last_in_word)
  );

endmodule

// ===== sim/jpeg_app_segment_value_extractor_top_tb.sv =====
// Self-checking testbench: streams JPEG bytes and checks the extracted annotation values.
module jpeg_app_segment_value_extractor_top_tb import jase_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 500000;
  localparam int TAIL_CYCLES  = 16;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic [2:0] value;
    logic       last_in_word;
  } value_rec_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_we        = 1'b0;
  logic        cfg_index     = 1'b0;
  logic [63:0] cfg_data      = 64'd0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte     = 8'd0;
  logic        start_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [2:0]  value;
  logic        last_in_word;

  int in_idle_max  = 16;
  int out_idle_max = 16;
  int ready_hold   = 0;
  int errors       = 0;
  int bytes_sent   = 0;
  int values_seen  = 0;
  int reg_writes   = 0;
  int cycle_count  = 0;
  logic resync_next = 1'b0;

  value_rec_t pending_values[$];
  logic [7:0] seg_bytes[$];

  logic [63:0] tag_setting;
  logic [7:0]  marker_setting;
  phase_t      parse_phase;
  logic [7:0]  last_byte;
  logic [3:0]  byte_idx;
  logic [15:0] seg_len;
  logic [63:0] tag_acc;
  logic [23:0] word_acc;
  logic [13:0] words_remaining;

  jpeg_app_segment_value_extractor_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .start_of_file(start_of_file),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value        (value),
    .last_in_word (last_in_word)
  );

  always #1 clk = ~clk;

  function automatic int draw_idle(input int max_gap);
    if (max_gap == 0 || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, max_gap);
  endfunction

  function automatic void clear_parse_state();
    parse_phase     = PH_SCAN;
    last_byte       = 8'd0;
    byte_idx        = 4'd0;
    seg_len         = 16'd0;
    tag_acc         = 64'd0;
    word_acc        = 24'd0;
    words_remaining = 14'd0;
  endfunction

  function automatic void resume_scan();
    parse_phase = PH_SCAN;
    byte_idx    = 4'd0;
    last_byte   = 8'd0;
  endfunction

  function automatic void predict_values(input logic [7:0] b, input logic sof);
    logic [15:0] word_count;
    logic [31:0] full_word;
    value_rec_t  rec;
    int          n;
    if (sof) clear_parse_state();
    case (parse_phase)
      PH_LEN: begin
        if (byte_idx == 4'd0) begin
          seg_len  = {b, 8'h00};
          byte_idx = 4'd1;
        end else begin
          seg_len = seg_len | {8'h00, b};
          if (seg_len >= MIN_TAG_LEN) begin
            parse_phase = PH_TAG;
            byte_idx    = 4'd0;
            tag_acc     = 64'd0;
          end else begin
            resume_scan();
          end
        end
      end
      PH_TAG: begin
        tag_acc  = {tag_acc[55:0], b};
        byte_idx = byte_idx + 4'd1;
        if (byte_idx >= 4'd8) begin
          word_count = (seg_len >= HEADER_LEN) ? (seg_len - HEADER_LEN) >> 2 : 16'd0;
          if (tag_acc == tag_setting && word_count != 16'd0) begin
            parse_phase     = PH_WORD;
            byte_idx        = 4'd0;
            word_acc        = 24'd0;
            words_remaining = word_count[13:0];
          end else begin
            resume_scan();
          end
        end
      end
      PH_WORD: begin
        if (byte_idx < 4'd3) begin
          word_acc = {word_acc[15:0], b};
          byte_idx = byte_idx + 4'd1;
        end else begin
          full_word = {word_acc, b};
          n = 0;
          while (n < VALUES_PER_WORD && full_word[3*n +: 3] != 3'd0) n++;
          for (int i = 0; i < n; i++) begin
            rec.value        = full_word[3*i +: 3];
            rec.last_in_word = (i == n - 1);
            pending_values   = {pending_values, rec};
          end
          byte_idx        = 4'd0;
          word_acc        = 24'd0;
          words_remaining = words_remaining - 14'd1;
          if (words_remaining == 14'd0) resume_scan();
        end
      end
      default: begin
        if (last_byte == MARKER_PREFIX && b == marker_setting) begin
          parse_phase = PH_LEN;
          byte_idx    = 4'd0;
          seg_len     = 16'd0;
        end
        last_byte = b;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic sof);
    int gap;
    gap = draw_idle(in_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    start_of_file <= sof;
    do @(posedge clk); while (!in_ready);
    predict_values(b, sof);
    bytes_sent++;
  endtask

  task automatic send_queued(input logic sof_first, input int limit);
    for (int i = 0; i < seg_bytes.size() && i < limit; i++)
      send_byte(seg_bytes[i], sof_first && i == 0);
    seg_bytes.delete();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TAG_WORD) tag_setting = data;
    else marker_setting = data[7:0];
    reg_writes++;
    @(posedge clk);
  endtask

  function automatic void queue_byte(input logic [7:0] b);
    seg_bytes = {seg_bytes, b};
  endfunction

  function automatic void push_header(input logic [7:0] mk, input logic [15:0] len);
    queue_byte(MARKER_PREFIX);
    queue_byte(mk);
    queue_byte(len[15:8]);
    queue_byte(len[7:0]);
  endfunction

  function automatic void push_tag(input logic [63:0] tag);
    for (int i = 7; i >= 0; i--) queue_byte(tag[8*i +: 8]);
  endfunction

  function automatic void push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) queue_byte(w[8*i +: 8]);
  endfunction

  function automatic logic [7:0] noise_byte();
    return 8'($urandom_range(0, 254));
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    logic [2:0]  f;
    int          k;
    w = $urandom;
    k = $urandom_range(0, VALUES_PER_WORD);
    for (int i = 0; i < k; i++) begin
      f = 3'($urandom_range(1, 7));
      if (w[3*i +: 3] == 3'd0) w[3*i +: 3] = f;
    end
    if (k < VALUES_PER_WORD) w[3*k +: 3] = 3'd0;
    return w;
  endfunction

  task automatic random_segment();
    int          n_words;
    int          pad;
    int          cut;
    logic        short_len;
    logic        sof;
    logic [15:0] len;
    logic [63:0] tag;
    logic [7:0]  mk;
    repeat ($urandom_range(0, 3)) queue_byte(noise_byte());
    mk        = ($urandom_range(0, 9) == 0) ? 8'($urandom) : marker_setting;
    n_words   = $urandom_range(0, 4);
    pad       = $urandom_range(0, 3);
    short_len = ($urandom_range(0, 7) == 0);
    len       = short_len ? 16'($urandom_range(0, 9)) : 16'(10 + 4 * n_words + pad);
    tag       = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : tag_setting;
    push_header(mk, len);
    if (len >= MIN_TAG_LEN) push_tag(tag);
    if (!short_len) begin
      repeat (n_words) push_word(random_word());
      repeat (pad) queue_byte(noise_byte());
    end
    sof         = resync_next || ($urandom_range(0, 19) == 0);
    resync_next = 1'b0;
    cut         = seg_bytes.size();
    // cut short now and then; resync the next request with start_of_file
    if ($urandom_range(0, 9) == 0) begin
      cut         = $urandom_range(1, seg_bytes.size());
      resync_next = 1'b1;
    end
    send_queued(sof, cut);
  endtask

  task automatic run_random_phase(input logic [63:0] tag, input logic [7:0] mk,
                                  input int in_max, input int out_max, input int n_bytes);
    int stop_bytes;
    int stop_values;
    wait_idle();
    write_reg(REG_TAG_WORD, tag);
    write_reg(REG_MARKER_CODE, {56'd0, mk});
    in_idle_max  = in_max;
    out_idle_max = out_max;
    stop_bytes   = bytes_sent + n_bytes;
    stop_values  = values_seen + 12;
    while (bytes_sent < stop_bytes || values_seen < stop_values) random_segment();
  endtask

  task automatic test_value_unpacking();
    push_header(MARKER_RESET, 16'd26);
    push_tag(TAG_WORD_RESET);
    push_word(32'hFFFF_FFFF);
    push_word(32'h0000_0008);
    push_word(32'h0000_0001);
    push_word(32'h0000_0611);
    send_queued(1'b0, seg_bytes.size());
  endtask

  task automatic test_short_lengths();
    push_header(MARKER_RESET, 16'd7);
    push_header(MARKER_RESET, 16'd8);
    push_tag(TAG_WORD_RESET);
    push_header(MARKER_RESET, 16'd9);
    push_tag(TAG_WORD_RESET);
    queue_byte(8'h5A);
    push_header(MARKER_RESET, 16'hFFFF);
    push_tag(64'h0000_0000_0000_00FF);
    // marker right after a trailing 0xFF tag byte must not open a segment
    queue_byte(MARKER_RESET);
    push_header(MARKER_RESET, 16'd14);
    push_tag(TAG_WORD_RESET);
    push_word(32'h0000_0007);
    send_queued(1'b0, seg_bytes.size());
  endtask

  task automatic test_start_of_file();
    push_header(MARKER_RESET, 16'd18);
    push_tag(TAG_WORD_RESET);
    queue_byte(8'h12);
    queue_byte(8'h34);
    send_queued(1'b0, seg_bytes.size());
    queue_byte(MARKER_PREFIX);
    queue_byte(MARKER_RESET);
    queue_byte(8'h00);
    queue_byte(8'h0E);
    push_tag(TAG_WORD_RESET);
    push_word(32'h0000_002F);
    send_queued(1'b1, seg_bytes.size());
  endtask

  task automatic test_marker_run();
    wait_idle();
    write_reg(REG_MARKER_CODE, 64'h0000_0000_0000_00FF);
    write_reg(REG_TAG_WORD, 64'd0);
    push_header(8'hFF, 16'd14);
    push_tag(64'd0);
    push_word(32'hC000_0249);
    send_queued(1'b0, seg_bytes.size());
  endtask

  task automatic test_random_traffic();
    run_random_phase({$urandom, $urandom}, MARKER_RESET, 16, 16, 40);
    run_random_phase(64'd0, 8'h00, 0, 0, 35);
    run_random_phase({64{1'b1}}, 8'hFF, 16, 0, 35);
    run_random_phase({$urandom, $urandom}, 8'($urandom), 0, 16, 35);
  endtask

  always @(posedge clk) begin : ready_pacing
    int w;
    if (rst) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (out_valid && out_ready) begin
      w = draw_idle(out_idle_max);
      out_ready  <= (w == 0);
      ready_hold <= w;
    end else if (!out_ready) begin
      if (ready_hold <= 1) out_ready <= 1'b1;
      if (ready_hold > 0) ready_hold <= ready_hold - 1;
    end
  end

  always @(posedge clk) begin : value_check
    value_rec_t want;
    if (!rst && out_valid && out_ready) begin
      values_seen++;
      if (pending_values.size() == 0) begin
        report_mismatch("unrequested value", value, 0);
      end else begin
        want = pending_values.pop_front();
        if (value !== want.value) report_mismatch("value", value, want.value);
        if (last_in_word !== want.last_in_word)
          report_mismatch("last_in_word", last_in_word, want.last_in_word);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    tag_setting    = TAG_WORD_RESET;
    marker_setting = MARKER_RESET;
    clear_parse_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_value_unpacking();
    test_short_lengths();
    test_start_of_file();
    test_marker_run();
    test_random_traffic();
    wait_idle();
    $display("streamed %0d bytes, checked %0d values over %0d register writes",
             bytes_sent, values_seen, reg_writes);
    $display("covered short and mismatched segments, resyncs, and stalls on both sides");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
